// ===== src/vsb_pkg.sv =====
// Shared widths, codes and controller/datapath interface types for the BDF-2 time stepper.
package vsb_pkg;

    localparam int TW        = 48;               // time and step width
    localparam int TF        = 32;               // time fraction bits
    localparam int WF        = 24;               // weight fraction bits
    localparam int QW        = 64;               // weight width
    localparam int QB        = QW - 1;           // quotient magnitude bits
    localparam int SH_HI     = TF + WF;          // numerator shift for weights
    localparam int SH_LO     = WF;               // numerator shift for extrapolation
    localparam int AW        = TW + 2;           // numerator base width
    localparam int XW        = TW + 1;           // denominator factor width
    localparam int DW        = 2 * XW;           // denominator width
    localparam int NW        = AW + SH_HI;       // shifted numerator width
    localparam int MUL_CHUNK = 16;
    localparam int MUL_STEPS = (XW + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int MSW       = $clog2(MUL_STEPS);
    localparam int RCW       = $clog2(QB);
    localparam int CW        = 32;               // step counter width
    localparam int LHSW      = TW + 8;           // end test width
    localparam int CFG_IW    = 3;

    localparam logic [TW-1:0] RST_START = TW'(0);
    localparam logic [TW-1:0] RST_END   = TW'(64'd4294967296);
    localparam logic [1:0]    RST_MODE  = 2'd0;
    localparam logic [TW-1:0] RST_INIT  = TW'(64'd42949673);
    localparam logic [TW-1:0] RST_MAX   = TW'(64'd429496730);
    localparam logic [TW-1:0] RST_MIN   = TW'(64'd4294967);
    localparam logic [QW-1:0] RST_WNEW  = QW'(64'd1677721598);
    localparam logic [QW-1:0] ONE_W     = QW'(1) << WF;
    localparam logic [1:0]    MODE_BDF2 = 2'd3;

    typedef enum logic [1:0] {
        OP_ADVANCE  = 2'd0,
        OP_SET_STEP = 2'd1,
        OP_PROPOSE  = 2'd2,
        OP_RESTART  = 2'd3
    } t_op;

    typedef enum logic [CFG_IW-1:0] {
        CFG_START = 3'd0,
        CFG_END   = 3'd1,
        CFG_MODE  = 3'd2,
        CFG_INIT  = 3'd3,
        CFG_MAX   = 3'd4,
        CFG_MIN   = 3'd5
    } t_cfg_idx;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_SET,
        DP_PROPOSE,
        DP_RESTART,
        DP_ADV_STEP,
        DP_ADV_CMP,
        DP_ADV_LAND,
        DP_RAT_GO,
        DP_RAT_STORE,
        DP_ADV_FINISH,
        DP_OUT_LOAD
    } t_dp_op;

    typedef enum logic [2:0] {
        R_NW,
        R_NW1,
        R_WP,
        R_WP2,
        R_EX,
        R_EX2
    } t_rsel;

    typedef struct packed {
        t_dp_op op;
        t_rsel  rsel;
        logic   status;
    } t_dp_cmd;

    typedef struct packed {
        logic end_flag;
        logic bdf;
        logic not_first;
        logic cnt_gt1;
        logic rat_done;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== src/vsb_ratio.sv =====
// Sequential (a << sh) / (x * y) unit: chunked multiply, then restoring divide, saturating.
module vsb_ratio (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_go,
    input  logic [vsb_pkg::AW-1:0]    i_a,
    input  logic                      i_hi,
    input  logic [vsb_pkg::XW-1:0]    i_x,
    input  logic [vsb_pkg::XW-1:0]    i_y,
    output logic                      o_done,
    output logic [vsb_pkg::QW-1:0]    o_q
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_CHK,
        S_DIV
    } t_state;

    localparam int YW = vsb_pkg::MUL_STEPS * vsb_pkg::MUL_CHUNK;

    t_state                          r_state;
    logic [vsb_pkg::XW-1:0]          r_x;
    logic [YW-1:0]                   r_y;
    logic [vsb_pkg::DW-1:0]          r_acc;
    logic [vsb_pkg::NW-1:0]          r_num;
    logic [vsb_pkg::DW-1:0]          r_rem;
    logic [vsb_pkg::QB-1:0]          r_q;
    logic [vsb_pkg::RCW-1:0]         r_cnt;
    logic                            r_done;

    logic [vsb_pkg::XW+vsb_pkg::MUL_CHUNK-1:0] pp;
    logic [vsb_pkg::DW:0]                      trial;
    logic [vsb_pkg::NW-vsb_pkg::QB-1:0]        top;
    logic                                      sat;
    logic                                      qbit;

    always_comb begin
        pp    = r_x * r_y[vsb_pkg::MUL_CHUNK-1:0];
        top   = r_num[vsb_pkg::NW-1:vsb_pkg::QB];
        sat   = (r_acc == '0) || (vsb_pkg::DW'(top) >= r_acc);
        trial = {r_rem, r_num[vsb_pkg::QB-1]};
        qbit  = (trial >= {1'b0, r_acc});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_done <= 1'b0;
                    if (i_go) begin
                        r_x     <= i_x;
                        r_y     <= YW'(i_y);
                        r_acc   <= '0;
                        r_num   <= i_hi ? (vsb_pkg::NW'(i_a) << vsb_pkg::SH_HI)
                                        : (vsb_pkg::NW'(i_a) << vsb_pkg::SH_LO);
                        r_cnt   <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_done <= 1'b0;
                    r_acc  <= r_acc + (vsb_pkg::DW'(pp)
                              << (vsb_pkg::MUL_CHUNK * r_cnt[vsb_pkg::MSW-1:0]));
                    r_y    <= r_y >> vsb_pkg::MUL_CHUNK;
                    if (r_cnt == vsb_pkg::RCW'(vsb_pkg::MUL_STEPS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_CHK;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_CHK: begin
                    // saturate if the divisor is zero or not above the top part; else the quotient stays below 2^63
                    if (sat) begin
                        r_q     <= '1;
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_done  <= 1'b0;
                        r_rem   <= vsb_pkg::DW'(top);
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= qbit ? vsb_pkg::DW'(trial - {1'b0, r_acc})
                                  : vsb_pkg::DW'(trial);
                    r_q   <= {r_q[vsb_pkg::QB-2:0], qbit};
                    r_num <= r_num << 1;
                    if (r_cnt == vsb_pkg::RCW'(vsb_pkg::QB - 1)) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_done <= 1'b0;
                        r_cnt  <= r_cnt + 1'b1;
                    end
                end
                default: begin
                    r_done  <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_q    = {1'b0, r_q};

endmodule

// ===== src/vsb_datapath.sv =====
// Stepper datapath: configuration, solver state, ratio unit and output register.
module vsb_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  vsb_pkg::t_dp_cmd              i_cmd,
    output vsb_pkg::t_dp_sts              o_sts,
    input  logic                          i_in_fire,
    input  logic [vsb_pkg::TW-1:0]        i_step_value,
    input  logic                          i_cfg_fire,
    input  logic [vsb_pkg::CFG_IW-1:0]    i_cfg_index,
    input  logic [vsb_pkg::TW-1:0]        i_cfg_data,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [vsb_pkg::TW-1:0]        o_time_now,
    output logic [vsb_pkg::TW-1:0]        o_cur_step,
    output logic signed [vsb_pkg::QW-1:0] o_weight_new,
    output logic signed [vsb_pkg::QW-1:0] o_weight_prev,
    output logic signed [vsb_pkg::QW-1:0] o_weight_prev2,
    output logic signed [vsb_pkg::QW-1:0] o_extrap_prev,
    output logic signed [vsb_pkg::QW-1:0] o_extrap_prev2,
    output logic                          o_weight_moved,
    output logic                          o_reached_end,
    output logic                          o_status
);

    localparam int TW = vsb_pkg::TW;
    localparam int QW = vsb_pkg::QW;

    // configuration
    logic [TW-1:0] r_start, r_end, r_init, r_max, r_min;
    logic [1:0]    r_mode;
    // solver state
    logic [TW-1:0]          r_now, r_cur, r_last, r_wanted;
    logic [QW-1:0]          r_wnew, r_wprev, r_wprev2, r_exprev, r_exprev2;
    logic [vsb_pkg::CW-1:0] r_count;
    logic                   r_end_flag, r_changed, r_nf, r_out_valid;
    // per-item scratch
    logic [vsb_pkg::LHSW-1:0] r_lhs, r_rhs;
    logic [TW-1:0]            r_h, r_val;
    logic [QW-1:0]            r_nw;

    logic                     bdf, nf, land;
    logic [vsb_pkg::XW-1:0]   bsum;
    logic [vsb_pkg::AW-1:0]   bsum2;
    logic [vsb_pkg::AW-1:0]   rat_a;
    logic                     rat_hi;
    logic [vsb_pkg::XW-1:0]   rat_x, rat_y;
    logic                     rat_done;
    logic [QW-1:0]            rat_q;
    logic [TW-1:0]            s_sel, s_new, h_sum, land_step;
    logic [TW-1:0]            p, half, pick, dbl, prop;

    always_comb begin
        bdf   = (r_mode == vsb_pkg::MODE_BDF2);
        nf    = (r_now != r_start);
        bsum  = vsb_pkg::XW'(r_cur) + vsb_pkg::XW'(r_last);
        bsum2 = vsb_pkg::AW'(bsum) + vsb_pkg::AW'(r_cur);

        s_sel = (nf && bdf && r_count == vsb_pkg::CW'(1)) ? r_wanted : r_cur;
        s_new = (nf && s_sel > r_max) ? r_max : s_sel;

        land      = (r_lhs > r_rhs);
        h_sum     = r_now + r_cur;
        land_step = (r_end >= r_now) ? r_end - r_now : '0;

        // proposal: clamp to [p/2, 2p], then to [min, max]
        p    = (r_now == '0) ? r_val : r_cur;
        half = p >> 1;
        pick = (r_val > half) ? r_val : half;
        dbl  = {p[TW-2:0], 1'b0};
        if (!p[TW-1] && dbl < pick) begin
            pick = dbl;
        end
        prop = (pick < r_min) ? r_min : pick;
        if (prop > r_max) begin
            prop = r_max;
        end

        rat_a  = '0;
        rat_hi = 1'b1;
        rat_x  = vsb_pkg::XW'(r_cur);
        rat_y  = vsb_pkg::XW'(1);
        case (i_cmd.rsel)
            vsb_pkg::R_NW: begin
                rat_a = bsum2;
                rat_y = bsum;
            end
            vsb_pkg::R_NW1: begin
                rat_a = vsb_pkg::AW'(1);
            end
            vsb_pkg::R_WP: begin
                rat_a = vsb_pkg::AW'(bsum);
                rat_y = vsb_pkg::XW'(r_last);
            end
            vsb_pkg::R_WP2: begin
                rat_a = vsb_pkg::AW'(r_cur);
                rat_x = vsb_pkg::XW'(r_last);
                rat_y = bsum;
            end
            vsb_pkg::R_EX: begin
                rat_a  = vsb_pkg::AW'(bsum);
                rat_hi = 1'b0;
                rat_x  = vsb_pkg::XW'(r_last);
            end
            vsb_pkg::R_EX2: begin
                rat_a  = vsb_pkg::AW'(r_cur);
                rat_hi = 1'b0;
                rat_x  = vsb_pkg::XW'(r_last);
            end
            default: rat_a = '0;
        endcase
    end

    vsb_ratio u_ratio (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.op == vsb_pkg::DP_RAT_GO),
        .i_a     (rat_a),
        .i_hi    (rat_hi),
        .i_x     (rat_x),
        .i_y     (rat_y),
        .o_done  (rat_done),
        .o_q     (rat_q)
    );

    // scratch registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_in_fire) begin
            r_val <= i_step_value;
        end
        case (i_cmd.op)
            vsb_pkg::DP_ADV_CMP: begin
                r_lhs <= vsb_pkg::LHSW'(r_now) * vsb_pkg::LHSW'(100)
                       + vsb_pkg::LHSW'(r_cur) * vsb_pkg::LHSW'(101);
                r_rhs <= vsb_pkg::LHSW'(r_end) * vsb_pkg::LHSW'(100);
            end
            vsb_pkg::DP_ADV_LAND: r_h <= land ? r_end : h_sum;
            vsb_pkg::DP_RAT_STORE: begin
                if (i_cmd.rsel == vsb_pkg::R_NW || i_cmd.rsel == vsb_pkg::R_NW1) begin
                    r_nw <= rat_q;
                end
            end
            default: r_h <= r_h;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start    <= vsb_pkg::RST_START;
            r_end      <= vsb_pkg::RST_END;
            r_mode     <= vsb_pkg::RST_MODE;
            r_init     <= vsb_pkg::RST_INIT;
            r_max      <= vsb_pkg::RST_MAX;
            r_min      <= vsb_pkg::RST_MIN;
            r_now      <= vsb_pkg::RST_START;
            r_cur      <= vsb_pkg::RST_INIT;
            r_wanted   <= vsb_pkg::RST_INIT;
            r_last     <= '0;
            r_wnew     <= vsb_pkg::RST_WNEW;
            r_wprev    <= QW'(0) - vsb_pkg::ONE_W;
            r_wprev2   <= '0;
            r_exprev   <= '0;
            r_exprev2  <= '0;
            r_count    <= '0;
            r_end_flag <= 1'b0;
            r_changed  <= 1'b1;
            r_nf       <= 1'b0;
        end else begin
            if (i_cfg_fire) begin
                case (vsb_pkg::t_cfg_idx'(i_cfg_index))
                    vsb_pkg::CFG_START: r_start <= i_cfg_data;
                    vsb_pkg::CFG_END:   r_end   <= i_cfg_data;
                    vsb_pkg::CFG_MODE:  r_mode  <= i_cfg_data[1:0];
                    vsb_pkg::CFG_INIT:  r_init  <= i_cfg_data;
                    vsb_pkg::CFG_MAX:   r_max   <= i_cfg_data;
                    vsb_pkg::CFG_MIN:   r_min   <= i_cfg_data;
                    default:            r_mode  <= r_mode;
                endcase
            end
            case (i_cmd.op)
                vsb_pkg::DP_SET: begin
                    r_cur    <= r_val;
                    r_wanted <= r_val;
                end
                vsb_pkg::DP_PROPOSE: begin
                    r_cur    <= prop;
                    r_wanted <= prop;
                end
                vsb_pkg::DP_RESTART: begin
                    r_count    <= '0;
                    r_now      <= r_start;
                    r_wanted   <= r_init;
                    r_cur      <= r_init;
                    r_last     <= '0;
                    r_end_flag <= (r_end <= r_start);
                    r_changed  <= 1'b1;
                end
                vsb_pkg::DP_ADV_STEP: begin
                    r_nf  <= nf;
                    r_cur <= s_new;
                    if (nf) begin
                        r_last <= r_cur;
                    end
                end
                vsb_pkg::DP_ADV_LAND: begin
                    if (land) begin
                        r_cur      <= land_step;
                        r_end_flag <= 1'b1;
                    end
                end
                vsb_pkg::DP_RAT_STORE: begin
                    case (i_cmd.rsel)
                        vsb_pkg::R_WP:  r_wprev   <= QW'(0) - rat_q;
                        vsb_pkg::R_WP2: r_wprev2  <= rat_q;
                        vsb_pkg::R_EX:  r_exprev  <= rat_q;
                        vsb_pkg::R_EX2: r_exprev2 <= QW'(0) - rat_q;
                        default:        r_wprev2  <= r_wprev2;
                    endcase
                end
                vsb_pkg::DP_ADV_FINISH: begin
                    r_changed <= (r_nw != r_wnew);
                    r_wnew    <= r_nw;
                    if (!(bdf && r_nf)) begin
                        r_wprev <= QW'(0) - r_nw;
                    end
                    if (!(r_count > vsb_pkg::CW'(1))) begin
                        r_exprev  <= vsb_pkg::ONE_W;
                        r_exprev2 <= '0;
                    end
                    r_now   <= r_h;
                    r_count <= r_count + 1'b1;
                end
                default: r_nf <= r_nf;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == vsb_pkg::DP_OUT_LOAD) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == vsb_pkg::DP_OUT_LOAD) begin
            o_time_now     <= r_now;
            o_cur_step     <= r_cur;
            o_weight_new   <= $signed(r_wnew);
            o_weight_prev  <= $signed(r_wprev);
            o_weight_prev2 <= $signed(r_wprev2);
            o_extrap_prev  <= $signed(r_exprev);
            o_extrap_prev2 <= $signed(r_exprev2);
            o_weight_moved <= r_changed;
            o_reached_end  <= r_end_flag;
            o_status       <= i_cmd.status;
        end
    end

    assign o_out_valid = r_out_valid;

    always_comb begin
        o_sts.end_flag  = r_end_flag;
        o_sts.bdf       = bdf;
        o_sts.not_first = r_nf;
        o_sts.cnt_gt1   = (r_count > vsb_pkg::CW'(1));
        o_sts.rat_done  = rat_done;
        o_sts.out_free  = !r_out_valid || i_out_ready;
    end

endmodule

// ===== src/vsb_ctrl.sv =====
// Stepper controller: sequences operations and the ratio chain of an advance.
module vsb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_fire,
    input  logic [1:0]        i_op,
    input  vsb_pkg::t_dp_sts  i_sts,
    output vsb_pkg::t_dp_cmd  o_cmd,
    output logic              o_in_ready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_LAND,
        S_RGO,
        S_RWAIT,
        S_FIN,
        S_OUT
    } t_state;

    t_state           r_state;
    vsb_pkg::t_dp_cmd r_cmd;
    vsb_pkg::t_rsel   r_sel;
    vsb_pkg::t_rsel   nxt_sel;
    logic             has_nxt;

    always_comb begin
        nxt_sel = vsb_pkg::R_EX;
        has_nxt = i_sts.cnt_gt1;
        case (r_sel)
            vsb_pkg::R_NW: begin
                nxt_sel = vsb_pkg::R_WP;
                has_nxt = 1'b1;
            end
            vsb_pkg::R_WP: begin
                nxt_sel = vsb_pkg::R_WP2;
                has_nxt = 1'b1;
            end
            vsb_pkg::R_EX: begin
                nxt_sel = vsb_pkg::R_EX2;
                has_nxt = 1'b1;
            end
            vsb_pkg::R_EX2: has_nxt = 1'b0;
            default:        has_nxt = i_sts.cnt_gt1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cmd.op     <= vsb_pkg::DP_NONE;
            r_cmd.rsel   <= vsb_pkg::R_NW;
            r_cmd.status <= 1'b0;
            r_sel        <= vsb_pkg::R_NW;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_fire) begin
                        case (vsb_pkg::t_op'(i_op))
                            vsb_pkg::OP_ADVANCE: begin
                                if (i_sts.end_flag) begin
                                    r_cmd.status <= 1'b1;
                                    r_cmd.op     <= vsb_pkg::DP_NONE;
                                    r_state      <= S_OUT;
                                end else begin
                                    r_cmd.status <= 1'b0;
                                    r_cmd.op     <= vsb_pkg::DP_ADV_STEP;
                                    r_state      <= S_CMP;
                                end
                            end
                            vsb_pkg::OP_SET_STEP: begin
                                r_cmd.status <= 1'b0;
                                r_cmd.op     <= vsb_pkg::DP_SET;
                                r_state      <= S_OUT;
                            end
                            vsb_pkg::OP_PROPOSE: begin
                                r_cmd.status <= 1'b0;
                                r_cmd.op     <= vsb_pkg::DP_PROPOSE;
                                r_state      <= S_OUT;
                            end
                            default: begin
                                r_cmd.status <= 1'b0;
                                r_cmd.op     <= vsb_pkg::DP_RESTART;
                                r_state      <= S_OUT;
                            end
                        endcase
                    end else begin
                        r_cmd.op <= vsb_pkg::DP_NONE;
                    end
                end
                S_CMP: begin
                    r_cmd.op <= vsb_pkg::DP_ADV_CMP;
                    r_state  <= S_LAND;
                end
                S_LAND: begin
                    r_cmd.op <= vsb_pkg::DP_ADV_LAND;
                    r_sel    <= (i_sts.bdf && i_sts.not_first) ? vsb_pkg::R_NW
                                                               : vsb_pkg::R_NW1;
                    r_state  <= S_RGO;
                end
                S_RGO: begin
                    r_cmd.op   <= vsb_pkg::DP_RAT_GO;
                    r_cmd.rsel <= r_sel;
                    r_state    <= S_RWAIT;
                end
                S_RWAIT: begin
                    if (i_sts.rat_done) begin
                        r_cmd.op   <= vsb_pkg::DP_RAT_STORE;
                        r_cmd.rsel <= r_sel;
                        if (has_nxt) begin
                            r_sel   <= nxt_sel;
                            r_state <= S_RGO;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end else begin
                        r_cmd.op <= vsb_pkg::DP_NONE;
                    end
                end
                S_FIN: begin
                    r_cmd.op <= vsb_pkg::DP_ADV_FINISH;
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    if (i_sts.out_free) begin
                        r_cmd.op <= vsb_pkg::DP_OUT_LOAD;
                        r_state  <= S_IDLE;
                    end else begin
                        r_cmd.op <= vsb_pkg::DP_NONE;
                    end
                end
                default: begin
                    r_cmd.op <= vsb_pkg::DP_NONE;
                    r_state  <= S_IDLE;
                end
            endcase
        end
    end

    assign o_cmd      = r_cmd;
    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ===== src/variable_step_bdf2_time_stepper_core.sv =====
// Top level of the variable-step BDF-2 time stepper.
//
//  channel | signals                          | direction | carries
//  --------+----------------------------------+-----------+-------------------------------
//  in      | i_in_valid / o_in_ready          | to core   | i_op, i_step_value
//  out     | o_out_valid / i_out_ready        | from core | time, step, weights, flags
//  cfg     | i_cfg_valid / o_cfg_ready        | to core   | i_cfg_index, i_cfg_data
//
// Set step, propose and restart update the state, then load the result into the output register.
// An advance runs 1 to 5 quotients one after another on one shared ratio unit; each
// quotient runs a chunked multiply, a saturation check and a restoring divide,
// and a saturating quotient skips its divide.
// A refused advance (end reached) returns its result with status 1.
// Reset is synchronous, active low, and loads the register reset values.
// A result waits in the output register while the next transfer is taken;
// the core stalls before loading a new result until that one is taken.
module variable_step_bdf2_time_stepper_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input items
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_op,
    input  logic [vsb_pkg::TW-1:0]         i_step_value,
    // result items
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [vsb_pkg::TW-1:0]         o_time_now,
    output logic [vsb_pkg::TW-1:0]         o_cur_step,
    output logic signed [vsb_pkg::QW-1:0]  o_weight_new,
    output logic signed [vsb_pkg::QW-1:0]  o_weight_prev,
    output logic signed [vsb_pkg::QW-1:0]  o_weight_prev2,
    output logic signed [vsb_pkg::QW-1:0]  o_extrap_prev,
    output logic signed [vsb_pkg::QW-1:0]  o_extrap_prev2,
    output logic                           o_weight_moved,
    output logic                           o_reached_end,
    output logic                           o_status,
    // register writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [vsb_pkg::CFG_IW-1:0]     i_cfg_index,
    input  logic [vsb_pkg::TW-1:0]         i_cfg_data
);

    vsb_pkg::t_dp_cmd cmd;
    vsb_pkg::t_dp_sts sts;
    logic             in_fire;
    logic             cfg_fire;

    // register writes are always taken; the host must write only while idle, which the core does not enforce
    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid;
    assign in_fire     = i_in_valid && o_in_ready;

    vsb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (in_fire),
        .i_op       (i_op),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_ready (o_in_ready)
    );

    vsb_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_in_fire      (in_fire),
        .i_step_value   (i_step_value),
        .i_cfg_fire     (cfg_fire),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_time_now     (o_time_now),
        .o_cur_step     (o_cur_step),
        .o_weight_new   (o_weight_new),
        .o_weight_prev  (o_weight_prev),
        .o_weight_prev2 (o_weight_prev2),
        .o_extrap_prev  (o_extrap_prev),
        .o_extrap_prev2 (o_extrap_prev2),
        .o_weight_moved (o_weight_moved),
        .o_reached_end  (o_reached_end),
        .o_status       (o_status)
    );

endmodule

// ===== sim/variable_step_bdf2_time_stepper_core_test.sv =====
// Self-checking testbench for the variable-step BDF-2 time stepper core.
module variable_step_bdf2_time_stepper_core_test;
    import vsb_pkg::*;

    localparam logic [TW-1:0] TMASK    = {TW{1'b1}};
    localparam logic [63:0]   SAT      = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int            CYC_LIMIT = 4_000_000;

    typedef struct {
        t_op           op;
        logic [TW-1:0] val;
    } t_item;

    typedef struct {
        logic [TW-1:0] tnow;
        logic [TW-1:0] step;
        logic [63:0]   wn, wp, wp2, ep, ep2;
        logic          moved, endr, status;
    } t_result;

    logic          i_clk, i_rst_n;
    logic          i_in_valid, o_in_ready;
    logic [1:0]    i_op;
    logic [TW-1:0] i_step_value;
    logic          o_out_valid, i_out_ready;
    logic [TW-1:0] o_time_now, o_cur_step;
    logic signed [QW-1:0] o_weight_new, o_weight_prev, o_weight_prev2;
    logic signed [QW-1:0] o_extrap_prev, o_extrap_prev2;
    logic          o_weight_moved, o_reached_end, o_status;
    logic          i_cfg_valid, o_cfg_ready;
    logic [CFG_IW-1:0] i_cfg_index;
    logic [TW-1:0] i_cfg_data;

    variable_step_bdf2_time_stepper_core u_dut (.*);

    // stimulus and scoreboard
    t_item   pending_q[$];
    t_item   cur_item;
    t_result result_q[$];
    bit      in_done;
    bit      calm;
    int      n_err, n_items, n_results, n_adv, n_refused, n_landed;
    int      cycles;

    // stepper shadow state
    logic [TW-1:0] c_start, c_end, c_init, c_max, c_min;
    logic [1:0]    c_mode;
    logic [TW-1:0] s_now, s_cur, s_last, s_want;
    logic [63:0]   s_wn, s_wp, s_wp2, s_ep, s_ep2;
    logic [31:0]   s_cnt;
    logic          s_end, s_chg;

    // exact quotient (a << sh) / (x * y), magnitude saturated
    function automatic logic [63:0] quot(logic [255:0] a, int sh,
                                         logic [255:0] x, logic [255:0] y);
        logic [255:0] d, q;
        d = x * y;
        if (d == 0) return SAT;
        q = (a << sh) / d;
        return (q > SAT) ? SAT : q[63:0];
    endfunction

    task automatic stepper_reset();
        c_start = RST_START; c_end = RST_END; c_mode = RST_MODE;
        c_init = RST_INIT; c_max = RST_MAX; c_min = RST_MIN;
        s_now = c_start; s_cur = c_init; s_last = '0;
        s_want = c_init;
        s_wn = quot(1, TF + WF, c_init, 1);
        s_wp = -(64'd1 << WF); s_wp2 = '0; s_ep = '0; s_ep2 = '0;
        s_cnt = '0; s_end = 1'b0; s_chg = 1'b1;
    endtask

    task automatic stepper_config(t_cfg_idx idx, logic [TW-1:0] v);
        case (idx)
            CFG_START: c_start = v;
            CFG_END:   c_end = v;
            CFG_MODE:  c_mode = v[1:0];
            CFG_INIT:  c_init = v;
            CFG_MAX:   c_max = v;
            CFG_MIN:   c_min = v;
            default: ;
        endcase
    endtask

    task automatic stepper_advance();
        logic [TW-1:0]  s;
        logic [63:0]    h, nw;
        logic [255:0]   lhs, rhs, bc, bl, bsum;
        bit             not_first;
        not_first = (s_now != c_start);
        s = s_cur;
        if (not_first) begin
            s_last = s_cur;
            if (c_mode == MODE_BDF2 && s_cnt == 1) s = s_want;
            if (s > c_max) s = c_max;
        end
        s_cur = s;
        h = 64'(s_now) + 64'(s);
        // land on end time once it is less than 1.01 steps away
        lhs = 256'(s_now) * 100 + 256'(s) * 101;
        rhs = 256'(c_end) * 100;
        if (lhs > rhs) begin
            s_cur = (c_end >= s_now) ? c_end - s_now : '0;
            h = 64'(c_end);
            s_end = 1'b1;
            n_landed++;
        end
        bc = 256'(s_cur);
        bl = 256'(s_last);
        bsum = bc + bl;
        if (c_mode == MODE_BDF2 && not_first) begin
            nw = quot(bsum + bc, TF + WF, bc, bsum);
            s_wp = -quot(bsum, TF + WF, bc, bl);
            s_wp2 = quot(bc, TF + WF, bl, bsum);
        end else begin
            nw = quot(1, TF + WF, bc, 1);
            s_wp = -nw;
        end
        s_chg = (nw != s_wn);
        s_wn = nw;
        if (s_cnt > 1) begin
            s_ep = quot(bsum, WF, bl, 1);
            s_ep2 = -quot(bc, WF, bl, 1);
        end else begin
            s_ep = 64'd1 << WF;
            s_ep2 = '0;
        end
        s_now = h[TW-1:0];
        s_cnt++;
    endtask

    task automatic stepper_propose(logic [TW-1:0] d);
        logic [TW-1:0] p, x;
        p = (s_now == 0) ? d : s_cur;
        x = (d > (p >> 1)) ? d : (p >> 1);
        if (p <= (TMASK >> 1) && {p, 1'b0} < {1'b0, x}) x = p << 1;
        if (x < c_min) x = c_min;
        if (x > c_max) x = c_max;
        s_cur = x;
        s_want = x;
    endtask

    task automatic stepper_apply(t_item it);
        t_result r;
        logic    st;
        st = 1'b0;
        case (it.op)
            OP_ADVANCE: begin
                if (s_end) begin
                    st = 1'b1;
                    n_refused++;
                end else begin
                    stepper_advance();
                    n_adv++;
                end
            end
            OP_SET_STEP: begin
                s_cur = it.val;
                s_want = it.val;
            end
            OP_PROPOSE: stepper_propose(it.val);
            default: begin
                s_cnt = '0; s_now = c_start; s_want = c_init; s_cur = c_init;
                s_last = '0; s_end = (c_end <= c_start); s_chg = 1'b1;
            end
        endcase
        r.tnow = s_now; r.step = s_cur; r.wn = s_wn; r.wp = s_wp; r.wp2 = s_wp2;
        r.ep = s_ep; r.ep2 = s_ep2; r.moved = s_chg; r.endr = s_end; r.status = st;
        result_q.push_back(r);
    endtask

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s got %h want %h (result %0d)", what, got, want, n_results);
        n_err++;
    endtask

    task automatic cmp(string what, logic [63:0] got, logic [63:0] want);
        if (got !== want) report(what, got, want);
    endtask

    function automatic bit idle_now();
        return !calm && ($urandom_range(99) < 25);
    endfunction

    // clock and cycle limit
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    // input transfer: predict at the accepting edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            stepper_apply(cur_item);
            in_done = 1'b1;
            n_items++;
        end
    end

    // input driver, changes on the falling edge
    always @(negedge i_clk) begin
        if (!i_in_valid || in_done) begin
            in_done = 1'b0;
            if (i_rst_n && pending_q.size() > 0 && !idle_now()) begin
                cur_item = pending_q.pop_front();
                i_op <= cur_item.op;
                i_step_value <= cur_item.val;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_ready <= !idle_now();
    end

    // result monitor
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (result_q.size() == 0) begin
                report("unexpected result", o_time_now, 0);
            end else begin
                e = result_q.pop_front();
                cmp("time_now", o_time_now, e.tnow);
                cmp("cur_step", o_cur_step, e.step);
                cmp("weight_new", o_weight_new, e.wn);
                cmp("weight_prev", o_weight_prev, e.wp);
                cmp("weight_prev2", o_weight_prev2, e.wp2);
                cmp("extrap_prev", o_extrap_prev, e.ep);
                cmp("extrap_prev2", o_extrap_prev2, e.ep2);
                cmp("weight_moved", o_weight_moved, e.moved);
                cmp("reached_end", o_reached_end, e.endr);
                cmp("status", o_status, e.status);
            end
            n_results++;
        end
    end

    task automatic cfg_write(t_cfg_idx idx, logic [TW-1:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        stepper_config(idx, v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic cfg_all(logic [TW-1:0] st, logic [TW-1:0] en, logic [1:0] md,
                           logic [TW-1:0] ini, logic [TW-1:0] mx, logic [TW-1:0] mn);
        cfg_write(CFG_START, st);
        cfg_write(CFG_END, en);
        cfg_write(CFG_MODE, TW'(md));
        cfg_write(CFG_INIT, ini);
        cfg_write(CFG_MAX, mx);
        cfg_write(CFG_MIN, mn);
    endtask

    task automatic push(t_op op, logic [TW-1:0] v);
        t_item it;
        it.op = op;
        it.val = v;
        pending_q.push_back(it);
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (pending_q.size() != 0 || i_in_valid || result_q.size() != 0);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [TW-1:0] rand_time();
        logic [TW-1:0] v;
        v = TW'({$urandom, $urandom});
        return v >> $urandom_range(TW - 1);
    endfunction

    // step values: zero, all ones, near the configured limits, between min and min + max, or anywhere
    function automatic logic [TW-1:0] rand_step();
        case ($urandom_range(7))
            0: return TW'({$urandom, $urandom});
            1: return '0;
            2: return TMASK;
            3: return c_min + TW'($urandom_range(3)) - 1;
            4: return c_max + TW'($urandom_range(3)) - 1;
            default: return c_min + TW'(({$urandom, $urandom}) % (64'(c_max) + 1));
        endcase
    endfunction

    task automatic random_items(int n);
        int r;
        push(OP_RESTART, rand_step());
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 62) push(OP_ADVANCE, rand_step());
            else if (r < 74) push(OP_SET_STEP, rand_step());
            else if (r < 90) push(OP_PROPOSE, rand_step());
            else push(OP_RESTART, rand_step());
        end
    endtask

    initial begin
        logic [TW-1:0] st;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0; i_op = OP_ADVANCE; i_step_value = '0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_index = CFG_START; i_cfg_data = '0;
        cycles = 0; n_err = 0; calm = 1'b0; in_done = 1'b0;
        stepper_reset();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset state, first step, set and propose edges, end landing, refusal
        push(OP_ADVANCE, '0);
        push(OP_ADVANCE, TMASK);
        push(OP_PROPOSE, '0);
        push(OP_PROPOSE, TMASK);
        push(OP_SET_STEP, 48'h1_0000_0000);
        push(OP_ADVANCE, '0);
        push(OP_ADVANCE, '0);
        push(OP_RESTART, '0);
        push(OP_SET_STEP, '0);                // zero divisor on first step
        push(OP_ADVANCE, '0);
        push(OP_RESTART, '0);
        push(OP_PROPOSE, 48'd1);              // proposal from time zero
        push(OP_SET_STEP, 48'h0_8000_0000);
        push(OP_ADVANCE, '0);
        push(OP_ADVANCE, '0);                 // lands on end time
        push(OP_ADVANCE, '0);                 // refused at end
        push(OP_RESTART, '0);
        drain();

        // BDF-2: second step takes the wanted step, variable-step weights after
        cfg_write(CFG_MODE, TW'(MODE_BDF2));
        push(OP_RESTART, '0);
        push(OP_PROPOSE, 48'h0_0200_0000);
        push(OP_ADVANCE, '0);
        push(OP_PROPOSE, 48'h0_0500_0000);
        push(OP_ADVANCE, '0);
        push(OP_ADVANCE, '0);
        push(OP_SET_STEP, 48'h0_0100_0000);
        push(OP_ADVANCE, '0);
        drain();

        // extreme settings
        cfg_all('0, TMASK, 2'd3, 48'd1, TMASK, 48'd1);
        random_items(100);
        drain();
        cfg_all(TMASK, '0, 2'd1, TMASK, 48'd1, TMASK);
        random_items(60);
        drain();
        cfg_all(48'h5_0000_0000, 48'h5_0000_0000, 2'd2, 48'd1, 48'd1, 48'd1);
        random_items(40);
        drain();
        cfg_all(48'h0, 48'h4_0000_0000, 2'd3, 48'h1000_0000, 48'h2000_0000,
                48'h0100_0000);
        calm = 1'b1;
        random_items(250);
        drain();
        calm = 1'b0;

        // random settings
        for (int ph = 0; ph < 10; ph++) begin
            st = (ph % 3 == 0) ? '0 : rand_time();
            cfg_all(st, st + rand_time(), 2'($urandom_range(3)),
                    rand_time() | 48'd1, rand_time() | 48'd1, rand_time() | 48'd1);
            random_items(115);
            drain();
        end

        repeat (400) @(posedge i_clk);
        $display("Covered %0d items, %0d results: %0d advances, %0d refused, %0d end landings",
                 n_items, n_results, n_adv, n_refused, n_landed);
        $display("Config phases over all modes and limit extremes, %0d mismatches", n_err);
        if (n_err == 0 && result_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
